@@ sv/u2c_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to CP1252 decoder package
// Shared types, constants and the code point lookup for the decoder.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int ACC_W      = 64;
  localparam int PEND_W     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW   = 2;
  localparam int QUEUE_CW   = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register index of decode_enable, taken from paddr[2].
  localparam logic REG_DECODE_ENABLE = 1'b0;

  localparam logic [7:0]  DOT_CHAR    = 8'h2E;
  localparam logic [13:0] ELLIPSIS_CP = 14'h2026;

  // Number of dots emitted for one ellipsis, minus one.
  localparam logic [1:0]  LAST_DOT    = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic {
    KIND_SINGLE = 1'b0,
    KIND_DOTS   = 1'b1
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  code;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } map_hit_t;

  // Windows-1252 bytes for code points above U+00FF, save U+017D, U+017E, U+2026.
  function automatic map_hit_t map_lookup(input logic [13:0] cp);
    map_hit_t r;
    r.hit = 1'b1;
    unique case (cp)
      14'h0152: r.code = 8'h8C;
      14'h0153: r.code = 8'h9C;
      14'h0160: r.code = 8'h8A;
      14'h0161: r.code = 8'h9A;
      14'h0178: r.code = 8'h9F;
      14'h0192: r.code = 8'h83;
      14'h02C6: r.code = 8'h88;
      14'h02DC: r.code = 8'h98;
      14'h2013: r.code = 8'h96;
      14'h2014: r.code = 8'h97;
      14'h2018: r.code = 8'h91;
      14'h2019: r.code = 8'h92;
      14'h201A: r.code = 8'h82;
      14'h201E: r.code = 8'h84;
      14'h201C: r.code = 8'h93;
      14'h201D: r.code = 8'h94;
      14'h2020: r.code = 8'h86;
      14'h2021: r.code = 8'h87;
      14'h2022: r.code = 8'h95;
      14'h2030: r.code = 8'h89;
      14'h2039: r.code = 8'h8B;
      14'h203A: r.code = 8'h9B;
      14'h20AC: r.code = 8'h80;
      14'h2122: r.code = 8'h99;
      default: begin
        r.hit  = 1'b0;
        r.code = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

@@ sv/utf8_to_cp1252_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to CP1252 decoder
// Turns a UTF-8 byte stream into single-byte Windows-1252 text.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions carry one byte of the encoded string plus a
// first_of_string flag that drops any unfinished sequence. Output
// transactions carry one decoded byte and last_of_run, which marks the
// final byte produced for an input byte. An input byte yields zero, one or
// (for U+2026) three output bytes.
// An accepted byte passes through the queue and then the output register
// before it is shown on the output. Throughput is one byte per cycle while
// the queue has room; the output register emits an ellipsis as three dots.
// A four-entry queue between the front end and the output stage absorbs
// those expansions and any receiver stall; in_ready drops only when it is
// full. Reset clears the sequence state, the queue and the output valid,
// and puts the block in bypass (decode_enable low), where every byte
// passes through unchanged.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_decoder (
  input  logic                          clk,
  input  logic                          rst,
  // Byte input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  u2c_pkg::in_item_t             in_data,
  // Decoded byte output channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output u2c_pkg::out_item_t            out_data,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [u2c_pkg::PADDR_W-1:0]   paddr,
  input  logic [u2c_pkg::PDATA_W-1:0]   pwdata,
  output logic [u2c_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import u2c_pkg::*;

  logic        decode_enable;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      head;
  queue_stat_t stat;

  // The register port never waits. The single register sits at index 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DECODE_ENABLE) ?
                  {{(PDATA_W-1){1'b0}}, decode_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DECODE_ENABLE) begin
      decode_enable <= pwdata[0];
    end
  end

  // Front end: sequence tracking and classification of each byte.
  u2c_front u_front (
    .clk           (clk),
    .rst           (rst),
    .decode_enable (decode_enable),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .stat          (stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Queue of pending output entries.
  u2c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  // Output stage: one byte per transaction.
  u2c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/u2c_front.sv @@
// ----------------------------------------------------------------------------
// Decoder front end
// Accepts bytes, tracks the UTF-8 sequence state and queues output entries.
// ----------------------------------------------------------------------------
module u2c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              decode_enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  u2c_pkg::in_item_t in_data,
  input  u2c_pkg::queue_stat_t stat,
  output logic              push,
  output u2c_pkg::entry_t   push_entry
);
  import u2c_pkg::*;

  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [PEND_W-1:0] pend_eff;
  logic [ACC_W-1:0]  acc_eff;
  logic [ACC_W-1:0]  folded;
  logic [7:0]        b;
  logic              produce;
  entry_t            entry;
  map_hit_t          mh;

  assign in_ready = !stat.full;
  assign b        = in_data.in_byte;
  assign pend_eff = in_data.first_of_string ? '0 : pending;
  assign acc_eff  = in_data.first_of_string ? '0 : acc;
  assign folded   = {acc_eff[ACC_W-7:0], 6'b0} + {{(ACC_W-8){1'b0}}, b} - 64'd128;
  assign mh       = map_lookup(folded[13:0]);

  always_comb begin
    pending_next = pend_eff;
    acc_next     = acc_eff;
    produce      = 1'b0;
    entry.kind   = KIND_SINGLE;
    entry.code   = b;
    if (!decode_enable) begin
      produce = 1'b1;
    end else if (pend_eff != '0) begin
      acc_next     = folded;
      pending_next = pend_eff - 1'b1;
      if (pending_next == '0) begin
        // Sequence complete: classify the finished code point.
        if (folded[ACC_W-1:8] == '0) begin
          produce    = 1'b1;
          entry.code = folded[7:0];
        end else if (folded[ACC_W-1:14] == '0 && folded[13:0] == ELLIPSIS_CP) begin
          produce    = 1'b1;
          entry.kind = KIND_DOTS;
          entry.code = DOT_CHAR;
        end else if (folded[ACC_W-1:14] == '0 && mh.hit) begin
          produce    = 1'b1;
          entry.code = mh.code;
        end
      end
    end else if (b[7]) begin
      priority if (b >= 8'd252) begin
        acc_next     = {{(ACC_W-8){1'b0}}, b - 8'd252};
        pending_next = 3'd5;
      end else if (b >= 8'd248) begin
        acc_next     = {{(ACC_W-8){1'b0}}, b - 8'd248};
        pending_next = 3'd4;
      end else if (b >= 8'd240) begin
        acc_next     = {{(ACC_W-8){1'b0}}, b - 8'd240};
        pending_next = 3'd3;
      end else if (b >= 8'd224) begin
        acc_next     = {{(ACC_W-8){1'b0}}, b - 8'd224};
        pending_next = 3'd2;
      end else if (b >= 8'd192) begin
        acc_next     = {{(ACC_W-8){1'b0}}, b - 8'd192};
        pending_next = 3'd1;
      end else begin
        // Stray continuation byte: dropped, state kept.
        pending_next = pend_eff;
      end
    end else begin
      acc_next = {{(ACC_W-8){1'b0}}, b};
      produce  = 1'b1;
    end
  end

  assign push       = in_valid && in_ready && produce;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      acc     <= '0;
    end else if (in_valid && in_ready) begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

endmodule

@@ sv/u2c_queue.sv @@
// ----------------------------------------------------------------------------
// Decoder entry queue
// Short shifting queue between the front end and the output stage.
// ----------------------------------------------------------------------------
module u2c_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  u2c_pkg::entry_t      push_entry,
  input  logic                 pop,
  output u2c_pkg::entry_t      head,
  output u2c_pkg::queue_stat_t stat
);
  import u2c_pkg::*;

  entry_t              slot [QUEUE_DEPTH];
  logic [QUEUE_CW-1:0] count;
  logic [QUEUE_CW-1:0] wr_pos;

  assign head       = slot[0];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign wr_pos     = pop ? count - 1'b1 : count;

  // Each slot either takes the new entry or shifts toward the head.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (push && wr_pos[QUEUE_AW-1:0] == QUEUE_AW'(i)) begin
        slot[i] <= push_entry;
      end else if (pop) begin
        slot[i] <= slot[i+1];
      end
    end
    if (push && wr_pos[QUEUE_AW-1:0] == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
      slot[QUEUE_DEPTH-1] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end
  end

endmodule

@@ sv/u2c_back.sv @@
// ----------------------------------------------------------------------------
// Decoder output stage
// Expands queued entries into output bytes held in an output register.
// ----------------------------------------------------------------------------
module u2c_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u2c_pkg::entry_t      head,
  input  u2c_pkg::queue_stat_t stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u2c_pkg::out_item_t   out_data
);
  import u2c_pkg::*;

  logic [1:0] dot_idx;
  logic       load;
  logic       last_now;

  assign load     = !out_valid || out_ready;
  assign last_now = (head.kind == KIND_SINGLE) || (dot_idx == LAST_DOT);
  assign pop      = load && !stat.empty && last_now;

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      out_data.out_byte    <= head.code;
      out_data.last_of_run <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dot_idx   <= '0;
    end else if (load) begin
      out_valid <= !stat.empty;
      if (!stat.empty) begin
        dot_idx <= last_now ? 2'd0 : dot_idx + 2'd1;
      end
    end
  end

endmodule
